>>> hw/rtl/wcmf_pkg.sv
// shared constants, types and register map of the 3x3 window filter
package wcmf_pkg;

    // geometry and pixel format
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int KSIZE      = 3;
    localparam int PIX_W      = 8;
    localparam int WIN_N      = KSIZE * KSIZE;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int LINE_W     = (KSIZE - 1) * PIX_W;

    // register field widths
    localparam int MODE_W    = 2;
    localparam int LVL_W     = 8;
    localparam int FW_W      = 11;
    localparam int FH_W      = 13;
    localparam int KROW_W    = 48;
    localparam int COEF_W    = 16;
    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 3;

    // result and position widths
    localparam int VAL_W = 16;
    localparam int ROW_W = 22;
    localparam int CNT_W = 22;
    localparam int WH_W  = FW_W + FH_W;

    // result buffer
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [MODE_W-1:0] {
        MODE_RAW    = 2'd0,
        MODE_CLAMP  = 2'd1,
        MODE_MEDIAN = 2'd2
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FILTER_MODE  = 3'd0,
        REG_BORDER_COPY  = 3'd1,
        REG_MAX_LEVEL    = 3'd2,
        REG_FRAME_WIDTH  = 3'd3,
        REG_FRAME_HEIGHT = 3'd4,
        REG_KERNEL_TOP   = 3'd5,
        REG_KERNEL_MID   = 3'd6,
        REG_KERNEL_BOT   = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [MODE_W-1:0] filter_mode;
        logic              border_copy;
        logic [LVL_W-1:0]  max_level;
        logic [FW_W-1:0]   frame_width;
        logic [FH_W-1:0]   frame_height;
        logic [KROW_W-1:0] kernel_row_top;
        logic [KROW_W-1:0] kernel_row_mid;
        logic [KROW_W-1:0] kernel_row_bot;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        filter_mode:    MODE_W'(1),
        border_copy:    1'b1,
        max_level:      LVL_W'(255),
        frame_width:    FW_W'(640),
        frame_height:   FH_W'(480),
        kernel_row_top: KROW_W'(0),
        kernel_row_mid: KROW_W'(64'd16777216),
        kernel_row_bot: KROW_W'(0)
    };

    typedef struct packed {
        logic [PIX_W-1:0] pixel_in;
        logic             is_flush;
    } in_word_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] value_out;
        logic                    frame_last;
    } out_word_t;

    // per-item flags decided at acceptance
    typedef struct packed {
        logic emit;
        logic border;
        logic last;
    } tag_t;

    typedef struct packed {
        tag_t             tag;
        logic [PIX_W-1:0] pix;
        logic [COL_W-1:0] col;
    } item_info_t;

    // line store clearing sweep after reset
    typedef struct packed {
        logic             active;
        logic [COL_W-1:0] addr;
    } clr_t;

    typedef logic [WIN_N-1:0][PIX_W-1:0] win_t;

endpackage

>>> hw/rtl/wcmf_ram.sv
// generic single-write, single-read ram with registered read data
module wcmf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // read port, old data on a colliding write
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/wcmf_ctrl.sv
// raster position tracking, output decision and line store clearing sweep
module wcmf_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  wcmf_pkg::cfg_t      cfg,
    input  logic                pix_acc,
    input  wcmf_pkg::in_word_t  pix,
    output wcmf_pkg::item_info_t item,
    output wcmf_pkg::clr_t      clr
);
    import wcmf_pkg::*;

    logic [COL_W-1:0] in_col_reg, in_col_next;
    logic [ROW_W-1:0] in_row_reg, in_row_next;
    logic [CNT_W-1:0] out_count_reg, out_count_next;
    logic             clr_active_reg, clr_active_next;
    logic [COL_W-1:0] clr_addr_reg, clr_addr_next;

    logic [FW_W-1:0]  w;
    logic [FH_W-1:0]  h;
    logic [WH_W-1:0]  wh;
    logic [FW_W-1:0]  col_ext;
    logic [FW_W-1:0]  ocol;
    logic [ROW_W-1:0] orow;
    logic             emit;
    logic             border;
    logic             last;
    logic             wrap;

    // geometry in use
    always_comb
    begin
        if (cfg.frame_width < FW_W'(KSIZE))
            w = FW_W'(KSIZE);
        else if (cfg.frame_width > FW_W'(MAX_WIDTH))
            w = FW_W'(MAX_WIDTH);
        else
            w = cfg.frame_width;

        if (cfg.frame_height < FH_W'(KSIZE))
            h = FH_W'(KSIZE);
        else if (cfg.frame_height > FH_W'(MAX_HEIGHT))
            h = FH_W'(MAX_HEIGHT);
        else
            h = cfg.frame_height;
    end

    assign wh      = WH_W'(w) * WH_W'(h);
    assign col_ext = FW_W'(in_col_reg);

    // output position and its classification
    always_comb
    begin
        emit = (in_row_reg >= ROW_W'(2)) || (in_row_reg == ROW_W'(1) && in_col_reg != '0);
        if (in_col_reg == '0)
        begin
            orow = in_row_reg - ROW_W'(2);
            ocol = w - FW_W'(1);
        end
        else
        begin
            orow = in_row_reg - ROW_W'(1);
            ocol = col_ext - FW_W'(1);
        end
        border = (orow == '0) || (orow >= ROW_W'(h) - ROW_W'(1)) ||
                 (ocol == '0) || (ocol >= w - FW_W'(1));
        last   = WH_W'(out_count_reg) >= wh - WH_W'(1);
        wrap   = (col_ext + FW_W'(1)) >= w;
    end

    // position update per accepted word
    always_comb
    begin
        in_col_next    = in_col_reg;
        in_row_next    = in_row_reg;
        out_count_next = out_count_reg;
        if (pix_acc)
        begin
            if (emit && last)
            begin
                in_col_next    = '0;
                in_row_next    = '0;
                out_count_next = '0;
            end
            else
            begin
                if (emit)
                    out_count_next = out_count_reg + CNT_W'(1);
                if (wrap)
                begin
                    in_col_next = '0;
                    in_row_next = in_row_reg + ROW_W'(1);
                end
                else
                begin
                    in_col_next = in_col_reg + COL_W'(1);
                end
            end
        end
    end

    // clearing sweep over the line store
    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg)
        begin
            clr_addr_next = clr_addr_reg + COL_W'(1);
            if (clr_addr_reg == COL_W'(MAX_WIDTH - 1))
                clr_active_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg     <= '0;
            in_row_reg     <= '0;
            out_count_reg  <= '0;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else
        begin
            in_col_reg     <= in_col_next;
            in_row_reg     <= in_row_next;
            out_count_reg  <= out_count_next;
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
        end
    end

    // item description for the window stage
    always_comb
    begin
        item.tag.emit   = emit;
        item.tag.border = border;
        item.tag.last   = last;
        item.pix        = pix.is_flush ? '0 : pix.pixel_in;
        item.col        = in_col_reg;
    end

    assign clr.active = clr_active_reg;
    assign clr.addr   = clr_addr_reg;

    // frame end returns the position to the origin
    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_acc && emit && last) |=>
            (in_col_reg == '0 && in_row_reg == '0 && out_count_reg == '0))
        else $error("position not cleared after frame end");

endmodule

>>> hw/rtl/wcmf_window.sv
// two line buffers in one ram and the 3x3 pixel window
module wcmf_window (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  wcmf_pkg::item_info_t item,
    input  wcmf_pkg::clr_t       clr,
    output logic                 win_valid,
    output wcmf_pkg::tag_t       win_tag,
    output wcmf_pkg::win_t       window
);
    import wcmf_pkg::*;

    logic              s1_valid_reg;
    item_info_t        s1_item_reg;
    logic              ram_wr_en;
    logic [COL_W-1:0]  ram_wr_addr;
    logic [LINE_W-1:0] ram_wr_data;
    logic [LINE_W-1:0] ram_rd_data;
    logic [LINE_W-1:0] line_data;
    logic              fwd_reg, fwd_next;
    logic [LINE_W-1:0] fwd_data_reg;
    logic [KSIZE-1:0][PIX_W-1:0] col_pix;
    win_t              win_reg, win_next;
    logic              win_valid_reg;
    tag_t              win_tag_reg;

    // accepted word enters while the ram read is under way
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (item_valid)
            s1_item_reg <= item;
    end

    // line store: low byte two rows up, high byte one row up
    always_comb
    begin
        ram_wr_en   = clr.active || s1_valid_reg;
        ram_wr_addr = clr.active ? clr.addr : s1_item_reg.col;
        ram_wr_data = clr.active ? '0 :
                      {s1_item_reg.pix, line_data[LINE_W-1:PIX_W]};
    end

    wcmf_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (item_valid),
        .rd_addr (item.col),
        .rd_data (ram_rd_data)
    );

    // forward a write that lands in the same cycle as the read of that column
    assign fwd_next = item_valid && ram_wr_en && (ram_wr_addr == item.col);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fwd_reg <= 1'b0;
        else if (item_valid)
            fwd_reg <= fwd_next;
    end

    always_ff @(posedge clk)
    begin
        if (item_valid)
            fwd_data_reg <= ram_wr_data;
    end

    assign line_data = fwd_reg ? fwd_data_reg : ram_rd_data;

    // new column enters the window on the right
    always_comb
    begin
        col_pix[0] = line_data[PIX_W-1:0];
        col_pix[1] = line_data[LINE_W-1:PIX_W];
        col_pix[2] = s1_item_reg.pix;
        for (int m = 0; m < KSIZE; m++)
        begin
            for (int n = 0; n < KSIZE - 1; n++)
                win_next[m * KSIZE + n] = win_reg[m * KSIZE + n + 1];
            win_next[m * KSIZE + KSIZE - 1] = col_pix[m];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg       <= '0;
            win_valid_reg <= 1'b0;
        end
        else
        begin
            win_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
                win_reg <= win_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
            win_tag_reg <= s1_item_reg.tag;
    end

    assign win_valid = win_valid_reg;
    assign win_tag   = win_tag_reg;
    assign window    = win_reg;

    // the clearing sweep owns the write port alone
    a_clear_excl: assert property (@(posedge clk) disable iff (!rst_n)
        clr.active |-> (!s1_valid_reg && !item_valid))
        else $error("line store written by an item during clearing");

endmodule

>>> hw/rtl/wcmf_calc.sv
// kernel sum and median pipeline with final saturation, clamp and border select
module wcmf_calc (
    input  logic                clk,
    input  logic                rst_n,
    input  wcmf_pkg::cfg_t      cfg,
    input  logic                win_valid,
    input  wcmf_pkg::tag_t      win_tag,
    input  wcmf_pkg::win_t      window,
    output logic                res_valid,
    output wcmf_pkg::out_word_t res
);
    import wcmf_pkg::*;

    localparam int PROD_W = PIX_W + 1 + COEF_W;
    localparam int RSUM_W = PROD_W + 2;
    localparam int ACC_W  = RSUM_W + 2;
    localparam int FRAC_W = 8;
    localparam int QUO_W  = ACC_W - FRAC_W;
    localparam logic signed [ACC_W-1:0] ACC_RND = ACC_W'((1 << FRAC_W) - 1);
    localparam logic signed [QUO_W-1:0] SAT_MAX = QUO_W'(32767);
    localparam logic signed [QUO_W-1:0] SAT_MIN = QUO_W'(-32768);

    typedef struct packed {
        logic             border;
        logic             last;
        logic [PIX_W-1:0] ctr;
    } side_t;

    function automatic logic [PIX_W-1:0] min2(input logic [PIX_W-1:0] a, b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [PIX_W-1:0] max2(input logic [PIX_W-1:0] a, b);
        return (a < b) ? b : a;
    endfunction

    function automatic logic [PIX_W-1:0] med3(input logic [PIX_W-1:0] a, b, c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    // returns {high, middle, low}
    function automatic logic [3*PIX_W-1:0] sort3(input logic [PIX_W-1:0] a, b, c);
        logic [PIX_W-1:0] lo1, hi1, hi2, lo2;
        lo1 = min2(a, b);
        hi1 = max2(a, b);
        hi2 = max2(hi1, c);
        lo2 = min2(hi1, c);
        return {hi2, max2(lo1, lo2), min2(lo1, lo2)};
    endfunction

    logic [KSIZE-1:0][KROW_W-1:0] kern;
    logic signed [PROD_W-1:0] prod_next [WIN_N];
    logic signed [PROD_W-1:0] prod_reg  [WIN_N];
    logic [3*PIX_W-1:0]       tri_next  [KSIZE];
    logic [3*PIX_W-1:0]       tri_reg   [KSIZE];
    logic signed [RSUM_W-1:0] rsum_next [KSIZE];
    logic signed [RSUM_W-1:0] rsum_reg  [KSIZE];
    logic [PIX_W-1:0]         mlo_next, mmid_next, mhi_next;
    logic [PIX_W-1:0]         mlo_reg, mmid_reg, mhi_reg;
    logic signed [ACC_W-1:0]  acc_next, acc_reg;
    logic [PIX_W-1:0]         med_reg;
    logic                     a_valid_reg, b_valid_reg, c_valid_reg;
    side_t                    side_a_reg, side_b_reg, side_c_reg;
    logic signed [ACC_W-1:0]  acc_rnd;
    logic signed [QUO_W-1:0]  quo;
    logic signed [VAL_W-1:0]  sat, clp, lvl, interior;

    assign kern = {cfg.kernel_row_bot, cfg.kernel_row_mid, cfg.kernel_row_top};

    // products and per-row sorts
    always_comb
    begin
        for (int m = 0; m < KSIZE; m++)
        begin
            for (int n = 0; n < KSIZE; n++)
            begin
                prod_next[m * KSIZE + n] =
                    $signed({1'b0, window[m * KSIZE + n]}) *
                    $signed(kern[m][COEF_W * n +: COEF_W]);
            end
            tri_next[m] = sort3(window[m * KSIZE], window[m * KSIZE + 1],
                                window[m * KSIZE + 2]);
        end
    end

    // row sums and median candidates
    always_comb
    begin
        for (int m = 0; m < KSIZE; m++)
        begin
            rsum_next[m] = RSUM_W'(prod_reg[m * KSIZE]) +
                           RSUM_W'(prod_reg[m * KSIZE + 1]) +
                           RSUM_W'(prod_reg[m * KSIZE + 2]);
        end
        mlo_next  = max2(max2(tri_reg[0][PIX_W-1:0], tri_reg[1][PIX_W-1:0]),
                         tri_reg[2][PIX_W-1:0]);
        mmid_next = med3(tri_reg[0][2*PIX_W-1:PIX_W], tri_reg[1][2*PIX_W-1:PIX_W],
                         tri_reg[2][2*PIX_W-1:PIX_W]);
        mhi_next  = min2(min2(tri_reg[0][3*PIX_W-1:2*PIX_W],
                              tri_reg[1][3*PIX_W-1:2*PIX_W]),
                         tri_reg[2][3*PIX_W-1:2*PIX_W]);
    end

    assign acc_next = ACC_W'(rsum_reg[0]) + ACC_W'(rsum_reg[1]) + ACC_W'(rsum_reg[2]);

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= win_valid && win_tag.emit;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < WIN_N; i++)
            prod_reg[i] <= prod_next[i];
        for (int m = 0; m < KSIZE; m++)
        begin
            tri_reg[m]  <= tri_next[m];
            rsum_reg[m] <= rsum_next[m];
        end
        side_a_reg <= '{border: win_tag.border, last: win_tag.last,
                        ctr: window[WIN_N / 2]};
        side_b_reg <= side_a_reg;
        side_c_reg <= side_b_reg;
        mlo_reg    <= mlo_next;
        mmid_reg   <= mmid_next;
        mhi_reg    <= mhi_next;
        acc_reg    <= acc_next;
        med_reg    <= med3(mlo_reg, mmid_reg, mhi_reg);
    end

    // truncate toward zero, saturate, clamp
    always_comb
    begin
        acc_rnd = acc_reg + (acc_reg[ACC_W-1] ? ACC_RND : '0);
        quo     = acc_rnd[ACC_W-1:FRAC_W];
        if (quo > SAT_MAX)
            sat = VAL_W'(SAT_MAX);
        else if (quo < SAT_MIN)
            sat = VAL_W'(SAT_MIN);
        else
            sat = quo[VAL_W-1:0];

        lvl = VAL_W'(cfg.max_level);
        if (sat[VAL_W-1])
            clp = '0;
        else if (sat > lvl)
            clp = lvl;
        else
            clp = sat;
    end

    // mode and border select
    always_comb
    begin
        case (mode_t'(cfg.filter_mode))
            MODE_RAW:    interior = sat;
            MODE_CLAMP:  interior = clp;
            MODE_MEDIAN: interior = VAL_W'(med_reg);
            default:     interior = '0;
        endcase

        if (side_c_reg.border)
            res.value_out = cfg.border_copy ? VAL_W'(side_c_reg.ctr) : '0;
        else
            res.value_out = interior;
        res.frame_last = side_c_reg.last;
    end

    assign res_valid = c_valid_reg;

endmodule

>>> hw/rtl/wcmf_fifo.sv
// small result buffer between the pipeline and the output channel
module wcmf_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  wcmf_pkg::out_word_t wr_word,
    input  logic                rd_en,
    output logic                rd_valid,
    output wcmf_pkg::out_word_t rd_word
);
    import wcmf_pkg::*;

    out_word_t          mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0] count_reg, count_next;

    // pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + FIFO_AW'(1) : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + FIFO_AW'(1) : rd_ptr_reg;
        count_next  = count_reg + FIFO_CW'(wr_en) - FIFO_CW'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_word;
    end

    assign rd_valid = count_reg != '0;
    assign rd_word  = mem_reg[rd_ptr_reg];

    // the credit scheme upstream keeps the buffer from overflowing
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (count_reg != FIFO_CW'(FIFO_DEPTH) || rd_en))
        else $error("result buffer overflow");

endmodule

>>> hw/rtl/window_convolution_median_filter.sv
// top level of the 3x3 convolution / median window filter
//
//  channel  direction  handshake              word
//  pix      in         pix_valid / pix_stall  in_word_t  {pixel_in, is_flush}
//  res      out        res_valid / res_stall  out_word_t {value_out, frame_last}
//  cfg      in         cfg_wr_en              cfg_index, cfg_data (48 bits)
//
// one pixel word is taken per clock while pix_stall is low; each result then passes
// the window, multiply, two adder and select stages before the output buffer.
// after reset the line store ram is cleared one column per cycle: pix_stall
// stays high until all 1024 columns are cleared, while configuration writes are taken as usual.
// up to eight results are held in the output buffer; once eight results are
// pending or in flight, pix_stall rises until res takes a word.
module window_convolution_median_filter (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               pix_valid,
    output logic                               pix_stall,
    input  wcmf_pkg::in_word_t                 pix,
    output logic                               res_valid,
    input  logic                               res_stall,
    output wcmf_pkg::out_word_t                res,
    input  logic                               cfg_wr_en,
    input  logic [wcmf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [wcmf_pkg::CFG_W-1:0]         cfg_data
);
    import wcmf_pkg::*;

    cfg_t               cfg_reg;
    logic               pix_acc;
    logic               res_acc;
    item_info_t         item;
    clr_t               clr;
    logic               win_valid;
    tag_t               win_tag;
    win_t               window;
    logic               calc_valid;
    out_word_t          calc_word;
    logic [FIFO_CW-1:0] cnt_reg, cnt_next;
    logic               reserve;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_FILTER_MODE:  cfg_reg.filter_mode    <= cfg_data[MODE_W-1:0];
                REG_BORDER_COPY:  cfg_reg.border_copy    <= cfg_data[0];
                REG_MAX_LEVEL:    cfg_reg.max_level      <= cfg_data[LVL_W-1:0];
                REG_FRAME_WIDTH:  cfg_reg.frame_width    <= cfg_data[FW_W-1:0];
                REG_FRAME_HEIGHT: cfg_reg.frame_height   <= cfg_data[FH_W-1:0];
                REG_KERNEL_TOP:   cfg_reg.kernel_row_top <= cfg_data[KROW_W-1:0];
                REG_KERNEL_MID:   cfg_reg.kernel_row_mid <= cfg_data[KROW_W-1:0];
                REG_KERNEL_BOT:   cfg_reg.kernel_row_bot <= cfg_data[KROW_W-1:0];
                default:          cfg_reg                <= cfg_reg;
            endcase
        end
    end

    // handshakes and result credits
    assign pix_stall = clr.active || (cnt_reg == FIFO_CW'(FIFO_DEPTH));
    assign pix_acc   = pix_valid && !pix_stall;
    assign res_acc   = res_valid && !res_stall;
    assign reserve   = pix_acc && item.tag.emit;
    assign cnt_next  = cnt_reg + FIFO_CW'(reserve) - FIFO_CW'(res_acc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    wcmf_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .pix_acc (pix_acc),
        .pix     (pix),
        .item    (item),
        .clr     (clr)
    );

    wcmf_window u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (pix_acc),
        .item       (item),
        .clr        (clr),
        .win_valid  (win_valid),
        .win_tag    (win_tag),
        .window     (window)
    );

    wcmf_calc u_calc (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .win_valid (win_valid),
        .win_tag   (win_tag),
        .window    (window),
        .res_valid (calc_valid),
        .res       (calc_word)
    );

    wcmf_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (calc_valid),
        .wr_word  (calc_word),
        .rd_en    (res_acc),
        .rd_valid (res_valid),
        .rd_word  (res)
    );

    // credits cover every result in flight or buffered
    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= FIFO_CW'(FIFO_DEPTH))
        else $error("result credit count beyond buffer depth");

    a_credit_held: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (cnt_reg != '0))
        else $error("result offered without a credit");

    a_no_take_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr.active |-> !calc_valid)
        else $error("result produced during line store clearing");

endmodule

>>> tb/window_convolution_median_filter_tb.sv
// self-checking testbench of the 3x3 convolution and median window filter
`timescale 1ns / 100ps

module window_convolution_median_filter_tb;

    import wcmf_pkg::*;

    // filter_mode code that selects no filter
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam logic [KROW_W-1:0] KROW_IDENTITY = 48'h0000_0100_0000;
    localparam int unsigned RANDOM_WORDS = 1550;
    localparam int unsigned DRAIN_PAUSE = 8;
    localparam int unsigned REPORT_LIMIT = 10;

    typedef struct {
        bit                      is_write;
        cfg_index_t              reg_idx;
        logic [CFG_W-1:0]        value;
        in_word_t                word;
        bit                      typed;
        out_word_t               want;
    } step_t;

    logic                 clk;
    logic                 rst_n;
    logic                 pix_valid;
    logic                 pix_stall;
    in_word_t             pix;
    logic                 res_valid;
    logic                 res_stall;
    out_word_t            res;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    // predictor state: registers, two line rows, window and raster position
    cfg_t             shadow_cfg;
    logic [PIX_W-1:0] line_mem [0:2*MAX_WIDTH-1];
    logic [PIX_W-1:0] win [0:WIN_N-1];
    int unsigned      row_pos;
    int unsigned      col_pos;
    int unsigned      out_cnt;

    // filtered pixels still to come from the block
    out_word_t   filtered_q [$];
    step_t       steps [$];
    bit          typed_valid;
    out_word_t   typed_word;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned eff_width;
    int unsigned eff_height;
    int unsigned words_driven;
    int unsigned results_checked;
    int unsigned frames_closed;
    int unsigned mismatches;

    window_convolution_median_filter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix       (pix),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // geometry in use: held to 3..hi
    function automatic int unsigned held_to(int unsigned v, int unsigned hi);
        return (v < 3) ? 3 : ((v > hi) ? hi : v);
    endfunction

    function automatic logic signed [VAL_W-1:0] kernel_sum();
        logic [KROW_W-1:0] rows [3];
        longint            acc;
        longint            q;
        rows[0] = shadow_cfg.kernel_row_top;
        rows[1] = shadow_cfg.kernel_row_mid;
        rows[2] = shadow_cfg.kernel_row_bot;
        acc = 0;
        for (int m = 0; m < 3; m++)
        begin
            for (int n = 0; n < 3; n++)
            begin
                acc += longint'(win[m*3+n]) * longint'($signed(rows[m][16*n +: 16]));
            end
        end
        // integer division truncates toward zero
        q = acc / 256;
        if (q > 32767)
        begin
            q = 32767;
        end
        if (q < -32768)
        begin
            q = -32768;
        end
        return VAL_W'(q);
    endfunction

    function automatic logic [PIX_W-1:0] median_of_window();
        logic [PIX_W-1:0] s [WIN_N];
        logic [PIX_W-1:0] t;
        for (int i = 0; i < WIN_N; i++)
        begin
            s[i] = win[i];
        end
        for (int i = 1; i < WIN_N; i++)
        begin
            for (int j = i; j > 0 && s[j-1] > s[j]; j--)
            begin
                t      = s[j];
                s[j]   = s[j-1];
                s[j-1] = t;
            end
        end
        return s[WIN_N/2];
    endfunction

    // shift one word into the window, return 1 when it yields a pixel
    function automatic bit window_filter_step(input in_word_t word, output out_word_t result);
        int unsigned             w;
        int unsigned             h;
        int unsigned             c;
        int unsigned             orow;
        int unsigned             ocol;
        logic [PIX_W-1:0]        p;
        logic [PIX_W-1:0]        top;
        logic [PIX_W-1:0]        mid;
        logic signed [VAL_W-1:0] v;
        bit                      emit;
        w = held_to(shadow_cfg.frame_width, MAX_WIDTH);
        h = held_to(shadow_cfg.frame_height, MAX_HEIGHT);
        p = word.is_flush ? '0 : word.pixel_in;
        c = col_pos % MAX_WIDTH;
        top = line_mem[c];
        mid = line_mem[MAX_WIDTH + c];
        win[0] = win[1];
        win[1] = win[2];
        win[2] = top;
        win[3] = win[4];
        win[4] = win[5];
        win[5] = mid;
        win[6] = win[7];
        win[7] = win[8];
        win[8] = p;
        line_mem[c] = mid;
        line_mem[MAX_WIDTH + c] = p;
        result = '0;
        emit = (row_pos >= 2) || (row_pos == 1 && col_pos >= 1);
        if (emit)
        begin
            if (col_pos == 0)
            begin
                orow = row_pos - 2;
                ocol = w - 1;
            end
            else
            begin
                orow = row_pos - 1;
                ocol = col_pos - 1;
            end
            if (orow == 0 || orow >= h - 1 || ocol == 0 || ocol >= w - 1)
            begin
                v = shadow_cfg.border_copy ? VAL_W'(win[4]) : '0;
            end
            else
            begin
                case (shadow_cfg.filter_mode)
                    MODE_RAW:
                    begin
                        v = kernel_sum();
                    end
                    MODE_CLAMP:
                    begin
                        v = kernel_sum();
                        if (v < 0)
                        begin
                            v = '0;
                        end
                        if (v > $signed({1'b0, shadow_cfg.max_level}))
                        begin
                            v = VAL_W'(shadow_cfg.max_level);
                        end
                    end
                    MODE_MEDIAN:
                    begin
                        v = VAL_W'(median_of_window());
                    end
                    default:
                    begin
                        v = '0;
                    end
                endcase
            end
            result.value_out = v;
            if (out_cnt >= w * h - 1)
            begin
                result.frame_last = 1'b1;
                row_pos = 0;
                col_pos = 0;
                out_cnt = 0;
                return 1'b1;
            end
            out_cnt++;
        end
        if (col_pos + 1 >= w)
        begin
            col_pos = 0;
            row_pos++;
        end
        else
        begin
            col_pos++;
        end
        return emit;
    endfunction

    function automatic void record_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        case (idx)
            REG_FILTER_MODE:  shadow_cfg.filter_mode    = data[MODE_W-1:0];
            REG_BORDER_COPY:  shadow_cfg.border_copy    = data[0];
            REG_MAX_LEVEL:    shadow_cfg.max_level      = data[LVL_W-1:0];
            REG_FRAME_WIDTH:  shadow_cfg.frame_width    = data[FW_W-1:0];
            REG_FRAME_HEIGHT: shadow_cfg.frame_height   = data[FH_W-1:0];
            REG_KERNEL_TOP:   shadow_cfg.kernel_row_top = data[KROW_W-1:0];
            REG_KERNEL_MID:   shadow_cfg.kernel_row_mid = data[KROW_W-1:0];
            default:          shadow_cfg.kernel_row_bot = data[KROW_W-1:0];
        endcase
    endfunction

    function automatic void note_mismatch(string what);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
        begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
    endfunction

    // directed table rows
    function automatic void add_write(cfg_index_t idx, logic [CFG_W-1:0] value);
        step_t s;
        s.is_write = 1'b1;
        s.reg_idx  = idx;
        s.value    = value;
        s.word     = '0;
        s.typed    = 1'b0;
        s.want     = '0;
        steps.insert(steps.size(), s);
    endfunction

    function automatic void add_word(logic [PIX_W-1:0] pixel, logic flush, bit typed,
                                     logic signed [VAL_W-1:0] val, logic last);
        step_t s;
        s.is_write = 1'b0;
        s.reg_idx  = REG_FILTER_MODE;
        s.value    = '0;
        s.word     = '{pixel_in: pixel, is_flush: flush};
        s.typed    = typed;
        s.want     = '{value_out: val, frame_last: last};
        steps.insert(steps.size(), s);
    endfunction

    function automatic logic [PIX_W-1:0] next_pixel(int unsigned style);
        case (style)
            0:       return $urandom_range(1) ? '1 : '0;
            1:       return PIX_W'($urandom_range(140, 100));
            default: return PIX_W'($urandom);
        endcase
    endfunction

    task automatic write_reg(cfg_index_t idx, logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // offer one pixel word and hold it until taken
    task automatic send_word(logic [PIX_W-1:0] pixel, logic flush, bit typed, out_word_t want);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pix_valid <= 1'b0;
            @(negedge clk);
        end
        pix_valid   <= 1'b1;
        pix         <= '{pixel_in: pixel, is_flush: flush};
        typed_valid <= typed;
        typed_word  <= want;
        do
        begin
            @(posedge clk);
        end
        while (pix_stall !== 1'b0);
        words_driven++;
    endtask

    // stop offering words and let every pending pixel come out
    task automatic wait_drained();
        @(negedge clk);
        pix_valid <= 1'b0;
        while (filtered_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_PAUSE) @(posedge clk);
    endtask

    // one random setting per phase, extremes forced in the early phases
    task automatic apply_settings(int unsigned phase);
        logic [MODE_W-1:0] mode;
        logic              border;
        logic [LVL_W-1:0]  level;
        logic [FW_W-1:0]   width;
        logic [FH_W-1:0]   height;
        logic [KROW_W-1:0] krow [3];
        mode   = ($urandom_range(9) == 0) ? MODE_UNUSED : MODE_W'($urandom_range(2));
        border = 1'($urandom_range(1));
        level  = ($urandom_range(3) == 0) ? LVL_W'($urandom_range(1)) : LVL_W'($urandom);
        width  = FW_W'($urandom_range(8, 3));
        height = FH_W'($urandom_range(6, 3));
        for (int k = 0; k < 3; k++)
        begin
            for (int n = 0; n < 3; n++)
            begin
                krow[k][16*n +: 16] = ($urandom_range(3) == 0) ? 16'($urandom)
                                    : 16'(int'($urandom_range(1024)) - 512);
            end
        end
        case (phase)
            1:
            begin
                mode = MODE_RAW;
                foreach (krow[k]) krow[k] = {3{16'h7FFF}};
            end
            2:
            begin
                mode = MODE_RAW;
                foreach (krow[k]) krow[k] = {3{16'h8000}};
            end
            3:
            begin
                mode  = MODE_CLAMP;
                level = '0;
            end
            4:
            begin
                mode  = MODE_CLAMP;
                level = '1;
            end
            5:
            begin
                mode = MODE_MEDIAN;
            end
            6:
            begin
                width  = '1;
                height = '1;
            end
            7:
            begin
                width  = '0;
                height = '0;
            end
            8:
            begin
                width  = FW_W'(MAX_WIDTH);
                height = FH_W'(MAX_HEIGHT);
            end
            9:
            begin
                mode   = MODE_MEDIAN;
                width  = FW_W'(2);
                height = FH_W'(MAX_HEIGHT);
            end
            default:
            begin
            end
        endcase
        write_reg(REG_FILTER_MODE, CFG_W'(mode));
        write_reg(REG_BORDER_COPY, CFG_W'(border));
        write_reg(REG_MAX_LEVEL, CFG_W'(level));
        write_reg(REG_FRAME_WIDTH, CFG_W'(width));
        write_reg(REG_FRAME_HEIGHT, CFG_W'(height));
        write_reg(REG_KERNEL_TOP, krow[0]);
        write_reg(REG_KERNEL_MID, krow[1]);
        write_reg(REG_KERNEL_BOT, krow[2]);
        eff_width  = held_to(width, MAX_WIDTH);
        eff_height = held_to(height, MAX_HEIGHT);
    endtask

    // receiver stalls
    always @(negedge clk)
    begin
        res_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // predictor update and result comparison
    always @(posedge clk)
    begin : score
        out_word_t predicted;
        out_word_t wanted;
        if (rst_n)
        begin
            if (cfg_wr_en)
            begin
                record_write(cfg_index, cfg_data);
            end
            if (pix_valid && pix_stall === 1'b0)
            begin
                if (window_filter_step(pix, predicted))
                begin
                    filtered_q.insert(filtered_q.size(), typed_valid ? typed_word : predicted);
                end
            end
            if (res_valid === 1'b1 && res_stall === 1'b0)
            begin
                if (filtered_q.size() == 0)
                begin
                    note_mismatch($sformatf("unexpected word value %0d last %0b",
                                            res.value_out, res.frame_last));
                end
                else
                begin
                    wanted = filtered_q.pop_front();
                    results_checked++;
                    if (wanted.frame_last)
                    begin
                        frames_closed++;
                    end
                    if (res.value_out !== wanted.value_out || res.frame_last !== wanted.frame_last)
                    begin
                        note_mismatch($sformatf(
                            "word %0d expected value %0d last %0b, got value %0d last %0b",
                            results_checked, wanted.value_out, wanted.frame_last,
                            res.value_out, res.frame_last));
                    end
                end
            end
        end
    end

    // stimulus
    initial
    begin
        int unsigned phase;
        int unsigned start_words;
        int unsigned frame_style;
        int unsigned pix_style;
        int unsigned n_pix;
        bit          streaming;

        pix_valid   = 1'b0;
        pix         = '0;
        res_stall   = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        typed_valid = 1'b0;
        typed_word  = '0;
        shadow_cfg  = CFG_RESET;
        foreach (line_mem[i]) line_mem[i] = '0;
        foreach (win[i]) win[i] = '0;
        row_pos         = 0;
        col_pos         = 0;
        out_cnt         = 0;
        words_driven    = 0;
        results_checked = 0;
        frames_closed   = 0;
        mismatches      = 0;
        send_idle_pct   = 16;
        recv_idle_pct   = 70;
        rst_n           = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // 3x3 frame, identity kernel: every output equals its own input pixel
        add_write(REG_FILTER_MODE, CFG_W'(MODE_CLAMP));
        add_write(REG_BORDER_COPY, CFG_W'(1));
        add_write(REG_MAX_LEVEL, CFG_W'(255));
        add_write(REG_FRAME_WIDTH, CFG_W'(3));
        add_write(REG_FRAME_HEIGHT, CFG_W'(3));
        add_write(REG_KERNEL_TOP, '0);
        add_write(REG_KERNEL_MID, KROW_IDENTITY);
        add_write(REG_KERNEL_BOT, '0);
        add_word(8'h00, 1'b0, 1'b0, 16'sd0, 1'b0);
        add_word(8'hFF, 1'b0, 1'b0, 16'sd0, 1'b0);
        add_word(8'h01, 1'b0, 1'b0, 16'sd0, 1'b0);
        add_word(8'h80, 1'b0, 1'b0, 16'sd0, 1'b0);
        add_word(8'hC8, 1'b0, 1'b1, 16'sd0, 1'b0);
        add_word(8'h7F, 1'b0, 1'b1, 16'sd255, 1'b0);
        add_word(8'hFE, 1'b0, 1'b1, 16'sd1, 1'b0);
        add_word(8'h55, 1'b0, 1'b1, 16'sd128, 1'b0);
        add_word(8'hAA, 1'b0, 1'b1, 16'sd200, 1'b0);
        add_word(8'hFF, 1'b1, 1'b1, 16'sd127, 1'b0);
        add_word(8'hFF, 1'b1, 1'b1, 16'sd254, 1'b0);
        add_word(8'h00, 1'b1, 1'b1, 16'sd85, 1'b0);
        add_word(8'hFF, 1'b1, 1'b1, 16'sd170, 1'b1);
        // unused mode with zeroed borders, flushes inside the frame: all zero
        add_write(REG_BORDER_COPY, CFG_W'(0));
        add_write(REG_FILTER_MODE, CFG_W'(MODE_UNUSED));
        add_word(8'hFF, 1'b0, 1'b0, 16'sd0, 1'b0);
        add_word(8'h80, 1'b0, 1'b0, 16'sd0, 1'b0);
        add_word(8'hFF, 1'b1, 1'b0, 16'sd0, 1'b0);
        add_word(8'h55, 1'b0, 1'b0, 16'sd0, 1'b0);
        add_word(8'hAA, 1'b0, 1'b1, 16'sd0, 1'b0);
        add_word(8'hFF, 1'b0, 1'b1, 16'sd0, 1'b0);
        add_word(8'h7F, 1'b1, 1'b1, 16'sd0, 1'b0);
        add_word(8'h01, 1'b0, 1'b1, 16'sd0, 1'b0);
        add_word(8'hFE, 1'b0, 1'b1, 16'sd0, 1'b0);
        add_word(8'h00, 1'b1, 1'b1, 16'sd0, 1'b0);
        add_word(8'h00, 1'b1, 1'b1, 16'sd0, 1'b0);
        add_word(8'h00, 1'b1, 1'b1, 16'sd0, 1'b0);
        add_word(8'h00, 1'b1, 1'b1, 16'sd0, 1'b1);

        // walk the directed table
        streaming = 1'b0;
        foreach (steps[i])
        begin
            if (steps[i].is_write)
            begin
                if (streaming)
                begin
                    wait_drained();
                end
                streaming = 1'b0;
                write_reg(steps[i].reg_idx, steps[i].value);
            end
            else
            begin
                streaming = 1'b1;
                send_word(steps[i].word.pixel_in, steps[i].word.is_flush,
                          steps[i].typed, steps[i].want);
            end
        end

        // random phases: mostly whole frames with their drain, some broken ones
        phase = 0;
        start_words = words_driven;
        while (words_driven - start_words < RANDOM_WORDS)
        begin
            wait_drained();
            phase++;
            if (words_driven - start_words >= 2 * RANDOM_WORDS / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else if (words_driven - start_words >= RANDOM_WORDS / 3)
            begin
                send_idle_pct = 70;
                recv_idle_pct = 16;
            end
            apply_settings(phase);
            if (eff_width * eff_height > 64)
            begin
                // long frames: a stretch of the frame only
                repeat ($urandom_range(120, 40)) send_word(PIX_W'($urandom), 1'b0, 1'b0, '0);
            end
            else
            begin
                n_pix = words_driven;
                while (words_driven - n_pix < 100)
                begin
                    frame_style = $urandom_range(9);
                    pix_style   = $urandom_range(3);
                    if (frame_style == 0)
                    begin
                        // noise with flushes anywhere
                        repeat ($urandom_range(20, 5))
                            send_word(next_pixel(pix_style), 1'($urandom_range(1)), 1'b0, '0);
                    end
                    else
                    begin
                        // style 1 cuts the frame short, style 2 lets pixels into the drain
                        repeat ((frame_style == 1) ? $urandom_range(eff_width * eff_height - 1, 1)
                                                   : eff_width * eff_height)
                            send_word(next_pixel(pix_style), 1'b0, 1'b0, '0);
                        if (frame_style != 1)
                        begin
                            repeat (eff_width + 1)
                                send_word(PIX_W'($urandom),
                                          (frame_style == 2) ? 1'($urandom_range(1)) : 1'b1,
                                          1'b0, '0);
                        end
                    end
                end
            end
        end

        wait_drained();
        $display("covered %0d words over %0d random settings plus the directed frames",
                 words_driven, phase);
        $display("checked %0d filtered words, %0d frames closed, %0d mismatches",
                 results_checked, frames_closed, mismatches);
        if (mismatches == 0 && filtered_q.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("timeout with %0d words outstanding", filtered_q.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
